[sv/racb_pkg.sv]
// Shared types and codes for the range add and count-below engine.
package racb_pkg;

  localparam int unsigned ModeW  = 2;
  localparam int unsigned IdxW   = 16;
  localparam int unsigned AmtW   = 32;
  localparam int unsigned ValW   = 64;
  localparam int unsigned CountW = 17;
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  localparam logic [ModeW-1:0] MODE_ADD   = 2'd0;
  localparam logic [ModeW-1:0] MODE_QUERY = 2'd1;
  localparam logic [ModeW-1:0] MODE_LOAD  = 2'd2;

  // Register index of element_count, taken from paddr bit 2.
  localparam logic REG_ELEMENT_COUNT = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_EX,
    ST_OUT
  } state_e;

endpackage

[sv/racb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module racb_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/range_add_count_below_engine.sv]
// Top level of the range add and count-below engine.
// The engine holds MAX_ELEMENTS signed 64-bit elements in a RAM, split into blocks of
// BLOCK_SIZE elements, each block with a pending add offset held in a second RAM. One
// word is handled at a time and in_ready_o is high only while the engine is idle. An
// accepted word splits left_index into a block number and a position inside the block
// with a shift and a mask, so BLOCK_SIZE must be a power of two. The range is then
// walked one step at a time through a shared read-modify-write unit; every step is a
// RAM read, then the add, compare or write-back. A range add spends one step on each
// element of a partly covered block and one step on each fully covered block. A range
// query reads every element of its range, then hands the count to the output register.
// Only a query produces a result word; the result sits in an output register and is
// held until taken. The block offsets reset to zero through a valid bit per block, so
// no clearing pass is needed. Elements read before they were ever loaded give an
// undefined count. element_count sits at byte address 0 of the APB port.
module range_add_count_below_engine
  import racb_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 65536,
  parameter int unsigned BLOCK_SIZE   = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ModeW-1:0]  mode_i,
  input  logic [IdxW-1:0]   left_index_i,
  input  logic [IdxW-1:0]   right_index_i,
  input  logic signed [AmtW-1:0] amount_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CountW-1:0] count_below_o
);

  localparam int unsigned IW  = $clog2(MAX_ELEMENTS);
  localparam int unsigned BC  = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int unsigned BW  = (BC > 1) ? $clog2(BC) : 1;
  localparam int unsigned PW  = $clog2(BLOCK_SIZE);
  localparam int unsigned WW  = (IW + 1 > CountW) ? IW + 1 : CountW;

  // Configuration register.
  logic [CountW-1:0] element_count_q;
  logic              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_ELEMENT_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      element_count_q <= CountW'(65536);
    end else if (cfg_we) begin
      element_count_q <= pwdata[CountW-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ELEMENT_COUNT) ? PdataW'(element_count_q) : '0;

  // Effective element count and clamped range.
  logic [WW-1:0] cnt_ext, n_w, left_w, right_w, rcl_w;
  assign cnt_ext = WW'(element_count_q);
  assign n_w     = (cnt_ext == '0) ? WW'(1) :
                   (cnt_ext > WW'(MAX_ELEMENTS)) ? WW'(MAX_ELEMENTS) : cnt_ext;
  assign left_w  = WW'(left_index_i);
  assign right_w = WW'(right_index_i);
  assign rcl_w   = (right_w >= n_w) ? n_w - WW'(1) : right_w;

  // Sequencer and datapath registers.
  state_e            state_q, state_d;
  logic [ModeW-1:0]  mode_q;
  logic [AmtW-1:0]   amt_q;
  logic [ValW-1:0]   sq_q;
  logic [WW-1:0]     remain_q;
  logic [IW-1:0]     idx_q;
  logic [BW-1:0]     blk_q;
  logic [PW-1:0]     pos_q;
  logic              full_q;
  logic              offv_vld_q;
  logic [BC-1:0]     off_vld_q;
  logic [CountW-1:0] cnt_q;
  logic              out_valid_q;
  logic [CountW-1:0] out_data_q;

  logic              in_acc;
  logic              go_walk, go_out0;
  logic [AmtW-1:0]   mag;
  logic [ValW-1:0]   amt64, offv, elem_rd, off_rd, sum_v;
  logic              less;
  logic              last_step;
  logic              out_load;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // Decide at acceptance whether there is any work and whether an empty query still answers.
  always_comb begin
    go_walk = 1'b0;
    go_out0 = 1'b0;
    case (mode_i)
      MODE_LOAD: go_walk = (left_w < n_w);
      MODE_ADD: go_walk = (left_w <= rcl_w);
      MODE_QUERY: begin
        go_walk = (left_w <= rcl_w);
        go_out0 = !(left_w <= rcl_w);
      end
      default: begin
        go_walk = 1'b0;
        go_out0 = 1'b0;
      end
    endcase
  end

  assign mag = amount_i[AmtW-1] ? (AmtW'(0) - AmtW'(amount_i)) : AmtW'(amount_i);

  // Shared execute unit.
  assign amt64 = {{(ValW-AmtW){amt_q[AmtW-1]}}, amt_q};
  assign offv  = offv_vld_q ? off_rd : '0;
  assign sum_v = elem_rd + offv;
  assign less  = $signed(sum_v) < $signed(sq_q);
  assign last_step = full_q ? (remain_q == WW'(BLOCK_SIZE)) : (remain_q == WW'(1));

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // RAM ports.
  logic          elem_we, off_we, ram_re;
  logic [ValW-1:0] elem_wdata, off_wdata;

  assign ram_re     = (state_q == ST_RD);
  assign elem_we    = (state_q == ST_EX) && (mode_q != MODE_QUERY) && !full_q;
  assign elem_wdata = (mode_q == MODE_LOAD) ? amt64 - offv : elem_rd + amt64;
  assign off_we     = (state_q == ST_EX) && full_q;
  assign off_wdata  = offv + amt64;

  racb_ram #(.Width(ValW), .Depth(MAX_ELEMENTS)) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (elem_we),
    .waddr_i (idx_q),
    .wdata_i (elem_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (elem_rd)
  );

  racb_ram #(.Width(ValW), .Depth(BC)) u_off_ram (
    .clk_i   (clk_i),
    .we_i    (off_we),
    .waddr_i (blk_q),
    .wdata_i (off_wdata),
    .re_i    (ram_re),
    .raddr_i (blk_q),
    .rdata_o (off_rd)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (go_walk) begin
            state_d = ST_RD;
          end else if (go_out0) begin
            state_d = ST_OUT;
          end
        end
      end
      ST_RD: state_d = ST_EX;
      ST_EX: begin
        if (mode_q == MODE_LOAD) begin
          state_d = ST_IDLE;
        end else if (last_step) begin
          state_d = (mode_q == MODE_QUERY) ? ST_OUT : ST_IDLE;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      off_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (off_we) begin
        off_vld_q[blk_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= cnt_q;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          mode_q   <= mode_i;
          amt_q    <= AmtW'(amount_i);
          sq_q     <= ValW'(mag) * ValW'(mag);
          remain_q <= (mode_i == MODE_LOAD) ? WW'(1) : rcl_w - left_w + WW'(1);
          idx_q    <= IW'(left_w);
          blk_q    <= BW'(left_w >> PW);
          pos_q    <= PW'(left_w);
          cnt_q    <= '0;
        end
      end
      ST_RD: begin
        full_q     <= (mode_q == MODE_ADD) && (pos_q == '0) &&
                      (remain_q >= WW'(BLOCK_SIZE));
        offv_vld_q <= off_vld_q[blk_q];
      end
      ST_EX: begin
        if (full_q) begin
          idx_q    <= idx_q + IW'(BLOCK_SIZE);
          remain_q <= remain_q - WW'(BLOCK_SIZE);
          blk_q    <= blk_q + BW'(1);
        end else begin
          idx_q    <= idx_q + IW'(1);
          remain_q <= remain_q - WW'(1);
          if (pos_q == PW'(BLOCK_SIZE - 1)) begin
            pos_q <= '0;
            blk_q <= blk_q + BW'(1);
          end else begin
            pos_q <= pos_q + PW'(1);
          end
        end
        if ((mode_q == MODE_QUERY) && less) begin
          cnt_q <= cnt_q + CountW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign count_below_o = out_data_q;

`ifndef ASSERT_OFF
  // A walk step is never issued once the range is used up.
  a_remain_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |-> (remain_q != '0))
    else $error("walk step with empty remainder");

  // A result waiting at the output is not dropped or replaced.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_data_q)))
    else $error("pending result lost");

  // A full-block step only happens for a range add.
  a_full_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EX && full_q) |-> (mode_q == MODE_ADD))
    else $error("offset update outside a range add");
`endif

endmodule

[tb/sv/range_add_count_below_checker.sv]
// Checker for the range add and count-below engine: predicts counts and compares results.
module range_add_count_below_checker
  import racb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  input  logic              pready,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [ModeW-1:0]  mode_i,
  input  logic [IdxW-1:0]   left_index_i,
  input  logic [IdxW-1:0]   right_index_i,
  input  logic signed [AmtW-1:0] amount_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [CountW-1:0] count_below_i,
  output int                mismatch_count,
  output int                pending_count
);

  localparam int unsigned MaxElements = 65536;

  // Effective value of every element, block offsets already folded in.
  logic [ValW-1:0]   effective_value [MaxElements];
  logic [CountW-1:0] element_count_q;
  logic [CountW-1:0] expected_counts [$];

  function automatic int unsigned active_elements();
    if (element_count_q == '0) return 1;
    if (element_count_q > MaxElements) return MaxElements;
    return element_count_q;
  endfunction

  // Applies one accepted word to the shadow array and queues a count for queries.
  task automatic apply_word(input logic [ModeW-1:0] mode, input int unsigned left,
                            input int unsigned right, input logic signed [AmtW-1:0] amt);
    int unsigned n;
    longint signed wide_amt;
    longint signed magnitude;
    longint signed threshold;
    int unsigned hits;
    n = active_elements();
    wide_amt = amt;
    if (mode == MODE_LOAD) begin
      if (left < n) effective_value[left] = wide_amt;
    end else if (mode == MODE_ADD || mode == MODE_QUERY) begin
      if (right >= n) right = n - 1;
      if (mode == MODE_ADD) begin
        for (int unsigned i = left; i <= right; i++)
          effective_value[i] = effective_value[i] + wide_amt;
      end else begin
        magnitude = (wide_amt < 0) ? -wide_amt : wide_amt;
        threshold = magnitude * magnitude;
        hits = 0;
        for (int unsigned i = left; i <= right; i++)
          if ($signed(effective_value[i]) < threshold) hits++;
        expected_counts.push_back(hits[CountW-1:0]);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      element_count_q <= CountW'(MaxElements);
      expected_counts.delete();
      mismatch_count <= 0;
      pending_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_ELEMENT_COUNT)
        element_count_q <= pwdata[CountW-1:0];
      if (in_valid_i && in_ready_i)
        apply_word(mode_i, left_index_i, right_index_i, amount_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_counts.size() == 0) begin
          if (mismatch_count < 10)
            $display("count_below word with nothing expected: got %0d", count_below_i);
          mismatch_count <= mismatch_count + 1;
        end else begin
          if (count_below_i !== expected_counts[0]) begin
            if (mismatch_count < 10)
              $display("count_below mismatch: expected %0d got %0d",
                       expected_counts[0], count_below_i);
            mismatch_count <= mismatch_count + 1;
          end
          void'(expected_counts.pop_front());
        end
      end
      pending_count <= expected_counts.size();
    end
  end

endmodule

[tb/sv/range_add_count_below_engine_tb.sv]
// Stimulus and verdict for the range add and count-below engine.
module range_add_count_below_engine_tb;
  import racb_pkg::*;

  localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned MaxElements = 65536;
  localparam int unsigned PrefixTarget = 700;
  localparam int unsigned WordsPerPhase = 60;
  // Worst add walks two partial blocks and every full block; allow well beyond that.
  localparam int unsigned SettleCycles = 3000;
  localparam int unsigned HoldOffCycles = 4000;
  localparam longint unsigned CycleLimit = 3000000;

  logic              clk_i;
  logic              rst_ni;
  logic              psel, penable, pwrite, pready;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata, prdata;
  logic              in_valid_i, in_ready_o;
  logic [ModeW-1:0]  mode_i;
  logic [IdxW-1:0]   left_index_i, right_index_i;
  logic signed [AmtW-1:0] amount_i;
  logic              out_valid_o, out_ready_i;
  logic [CountW-1:0] count_below_o;
  int                mismatch_count, pending_count;

  // Idle pattern: 0 none, 1 sender idles, 2 receiver stalls, 3 both.
  int                idle_mode;
  bit                start_hold_off;
  longint unsigned   cycle_count = 0;
  // All elements below loaded_prefix have been written, so ranges inside it are safe.
  int unsigned       loaded_prefix;
  int unsigned       active_n;

  range_add_count_below_engine u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .mode_i, .left_index_i, .right_index_i, .amount_i,
    .out_valid_o, .out_ready_i, .count_below_o
  );

  range_add_count_below_checker u_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_ready_i(in_ready_o), .mode_i, .left_index_i, .right_index_i,
    .amount_i, .out_valid_i(out_valid_o), .out_ready_i, .count_below_i(count_below_o),
    .mismatch_count, .pending_count
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver. A hold-off request keeps ready low for a long stretch, so the single
  // result register fills and the engine stops taking words.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (start_hold_off) begin
        start_hold_off = 1'b0;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else if (idle_mode >= 2) begin
        out_ready_i = ($urandom_range(0, 99) >= 52);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // Offers one word and returns at the falling edge after it was taken. Valid stays
  // high on return, so back-to-back words do not drop it unless the sender idles.
  task automatic send_word(input logic [ModeW-1:0] mode, input int unsigned left,
                           input int unsigned right, input logic signed [AmtW-1:0] amt);
    while ((idle_mode == 1 || idle_mode == 3) && $urandom_range(0, 99) < 52) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    mode_i = mode;
    left_index_i = left[IdxW-1:0];
    right_index_i = right[IdxW-1:0];
    amount_i = amt;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    if (mode == MODE_LOAD && left == loaded_prefix && left < active_n) loaded_prefix++;
  endtask

  // Waits until every count has come back, then gives adds time to finish.
  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_element_count(input logic [PdataW-1:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = '0;
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    if (value[CountW-1:0] == 0) active_n = 1;
    else if (value[CountW-1:0] > MaxElements) active_n = MaxElements;
    else active_n = value[CountW-1:0];
  endtask

  // Load values are mostly small so that squares of query bases split them.
  function automatic logic signed [AmtW-1:0] random_amount();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $signed(AmtW'($urandom_range(0, 200000))) - 100000;
  endfunction

  function automatic logic signed [AmtW-1:0] random_base();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return $signed(AmtW'($urandom_range(0, 800))) - 400;
  endfunction

  // One random word: loads that grow or rewrite the array, adds and queries on
  // loaded ranges, and some noise (unused mode, empty ranges, loads out of range).
  task automatic random_word();
    int unsigned pick, top_index, left, right, bound;
    pick = $urandom_range(0, 99);
    top_index = (loaded_prefix < active_n) ? loaded_prefix : active_n;
    if (pick < 25) begin
      if ($urandom_range(0, 1) == 0 && loaded_prefix > 0)
        send_word(MODE_LOAD, $urandom_range(0, loaded_prefix - 1), $urandom, random_amount());
      else
        send_word(MODE_LOAD, $urandom_range(0, MaxElements - 1), $urandom, random_amount());
    end else if (pick < 32 || top_index == 0) begin
      if ($urandom_range(0, 1) == 0) begin
        send_word(MODE_UNUSED, $urandom_range(0, MaxElements - 1),
                  $urandom_range(0, MaxElements - 1), $urandom);
      end else begin
        // Left beyond the clamped right end gives an empty range.
        right = $urandom_range(0, MaxElements - 1);
        bound = (right < active_n - 1) ? right : active_n - 1;
        if (bound < MaxElements - 1) begin
          left = $urandom_range(bound + 1, MaxElements - 1);
          send_word($urandom_range(0, 1) ? MODE_ADD : MODE_QUERY, left, right, $urandom);
        end
      end
    end else begin
      left = $urandom_range(0, top_index - 1);
      if ($urandom_range(0, 14) == 0) right = top_index - 1;
      else right = left + $urandom_range(0, 40);
      if (right > top_index - 1) right = top_index - 1;
      // When the whole active array is loaded, a right end past it is clamped.
      if (loaded_prefix >= active_n && $urandom_range(0, 5) == 0)
        right = $urandom_range(active_n - 1, MaxElements - 1);
      if (pick < 62) send_word(MODE_ADD, left, right, random_amount());
      else send_word(MODE_QUERY, left, right, random_base());
    end
  endtask

  initial begin
    logic [PdataW-1:0] phase_counts [8];
    phase_counts = '{32'd65536, 32'd300, 32'd1, 32'd0, 32'd1000, 32'h1FFFF, 32'd40, 32'd700};
    idle_mode = 0;
    start_hold_off = 1'b0;
    loaded_prefix = 0;
    active_n = MaxElements;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    mode_i = MODE_ADD;
    left_index_i = '0;
    right_index_i = '0;
    amount_i = '0;
    rst_ni = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed words at the reset element count: amount extremes, every mode,
    // empty ranges, squares at both ends and an add that crosses the sign.
    send_word(MODE_LOAD, 0, 0, 32'sh8000_0000);
    send_word(MODE_LOAD, 1, 0, 32'sh7FFF_FFFF);
    send_word(MODE_LOAD, 2, 0, 0);
    send_word(MODE_LOAD, 3, 0, 1);
    send_word(MODE_LOAD, 4, 0, -1);
    send_word(MODE_LOAD, 5, 65535, 12345);
    send_word(MODE_LOAD, 40000, 0, 7);
    send_word(MODE_QUERY, 0, 5, 0);
    send_word(MODE_QUERY, 0, 5, 32'sh8000_0000);
    send_word(MODE_QUERY, 0, 5, 32'sh7FFF_FFFF);
    send_word(MODE_QUERY, 2, 4, -1);
    send_word(MODE_QUERY, 65535, 0, 3);
    send_word(MODE_ADD, 0, 5, 32'sh7FFF_FFFF);
    send_word(MODE_ADD, 1, 1, 32'sh8000_0000);
    send_word(MODE_ADD, 50000, 3, 9);
    send_word(MODE_UNUSED, 65535, 65535, -1);
    send_word(MODE_QUERY, 0, 5, 111);
    send_word(MODE_QUERY, 3, 3, 1);

    for (int p = 0; p < 8; p++) begin
      drain();
      idle_mode = p % 4;
      if (p != 0) write_element_count(phase_counts[p]);
      // Grow the loaded prefix first so that later ranges can span blocks.
      while (loaded_prefix < PrefixTarget && loaded_prefix < active_n)
        send_word(MODE_LOAD, loaded_prefix, $urandom, random_amount());
      if (p == 4) start_hold_off = 1'b1;
      for (int k = 0; k < WordsPerPhase; k++) random_word();
    end

    drain();
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[range_add_count_below_engine.f]
sv/racb_pkg.sv
sv/racb_ram.sv
sv/range_add_count_below_engine.sv
tb/sv/range_add_count_below_checker.sv
tb/sv/range_add_count_below_engine_tb.sv
